/* rtl/ors_pkg.sv */
// Shared types, codes and the CRC-8 helper for the 1-Wire ROM search engine.
package ors_pkg;

   // Item kind carried on the request tuser field.
   typedef enum logic [1:0] {
      FUNC_NEXT  = 2'd0,
      FUNC_FIRST = 2'd1,
      FUNC_BIT   = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   localparam int unsigned POS_W      = 7;
   localparam int unsigned ROM_W      = 64;
   localparam int unsigned FAMDISC_W  = 4;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned RSP_USER_W = 3;

   localparam logic [POS_W-1:0] FIRST_BIT    = 7'd1;
   localparam logic [POS_W-1:0] LAST_BIT     = 7'd65 - 7'd1;
   localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;
   localparam logic [7:0]       CRC_POLY     = 8'h8C;

   typedef struct packed {
      logic          complement_bit;
      logic          id_bit;
      logic          presence;
      logic [1:0]    func;
   } req_item_type;

   typedef struct packed {
      logic [FAMDISC_W-1:0] family_discrepancy;
      logic [ROM_W-1:0]     rom_code;
      logic                 found;
      logic                 done_res;
      logic                 write_bit;
      logic                 write_valid;
   } rsp_item_type;

   // Fold one byte into the CRC, LSB first, reflected polynomial.
   function automatic logic [7:0] crc_byte(input logic [7:0] crc_i, input logic [7:0] data_i);
      logic [7:0] crc;
      logic [7:0] data;
      logic       mix;
      crc  = crc_i;
      data = data_i;
      for (int i = 0; i < 8; i++) begin
         mix  = crc[0] ^ data[0];
         crc  = crc >> 1;
         if (mix) begin
            crc = crc ^ CRC_POLY;
         end
         data = data >> 1;
      end
      return crc;
   endfunction

endpackage

/* rtl/ors_in_reg.sv */
// Input register stage: capture one request item and hold it until the engine takes it.
module ors_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ors_pkg::req_item_type req_item,
   input  logic                  take,
   output logic                  item_valid,
   output ors_pkg::req_item_type item
);

   logic                  valid_ff, valid_in;
   ors_pkg::req_item_type item_ff, item_in;

   // Accept whenever the held item leaves this cycle or the stage is empty.
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/ors_engine.sv */
// Search ROM state and the combinational update for one item.
module ors_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ors_pkg::req_item_type item,
   output ors_pkg::rsp_item_type result
);

   logic [ors_pkg::ROM_W-1:0]     rom_ff, rom_in;
   logic [ors_pkg::POS_W-1:0]     last_disc_ff, last_disc_in;
   logic [ors_pkg::FAMDISC_W-1:0] fam_disc_ff, fam_disc_in;
   logic                          last_dev_ff, last_dev_in;
   logic [7:0]                    crc_ff, crc_in;
   logic [ors_pkg::POS_W-1:0]     bit_pos_ff, bit_pos_in;
   logic [ors_pkg::POS_W-1:0]     zero_pos_ff, zero_pos_in;
   logic                          searching_ff, searching_in;

   logic [5:0]                    idx;
   logic                          dir;
   logic [7:0]                    byte_sel;

   always_comb begin
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      fam_disc_in  = fam_disc_ff;
      last_dev_in  = last_dev_ff;
      crc_in       = crc_ff;
      bit_pos_in   = bit_pos_ff;
      zero_pos_in  = zero_pos_ff;
      searching_in = searching_ff;
      idx          = bit_pos_ff[5:0] - 6'd1;
      dir          = 1'b0;
      byte_sel     = 8'd0;
      result       = '0;

      case (item.func)
         ors_pkg::FUNC_NEXT, ors_pkg::FUNC_FIRST: begin
            // A first search forgets what earlier passes learned.
            if (item.func == ors_pkg::FUNC_FIRST) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
            end
            if (last_dev_in || !item.presence) begin
               last_disc_in    = '0;
               fam_disc_in     = '0;
               last_dev_in     = 1'b0;
               searching_in    = 1'b0;
               result.done_res = 1'b1;
            end else begin
               searching_in = 1'b1;
               bit_pos_in   = ors_pkg::FIRST_BIT;
               zero_pos_in  = '0;
               crc_in       = '0;
            end
         end
         ors_pkg::FUNC_BIT: begin
            if (searching_ff) begin
               if (item.id_bit && item.complement_bit) begin
                  // No device answered: drop the search.
                  last_disc_in    = '0;
                  fam_disc_in     = '0;
                  last_dev_in     = 1'b0;
                  searching_in    = 1'b0;
                  result.done_res = 1'b1;
               end else begin
                  if (item.id_bit != item.complement_bit) begin
                     dir = item.id_bit;
                  end else begin
                     // Discrepancy: follow the earlier path, then take the one branch once.
                     if (bit_pos_ff < last_disc_ff) begin
                        dir = rom_ff[idx];
                     end else begin
                        dir = (bit_pos_ff == last_disc_ff);
                     end
                     if (!dir) begin
                        zero_pos_in = bit_pos_ff;
                        if (bit_pos_ff < ors_pkg::FAMILY_LIMIT) begin
                           fam_disc_in = bit_pos_ff[ors_pkg::FAMDISC_W-1:0];
                        end
                     end
                  end
                  rom_in[idx]        = dir;
                  result.write_valid = 1'b1;
                  result.write_bit   = dir;
                  byte_sel           = rom_in[{idx[5:3], 3'b000} +: 8];
                  if (bit_pos_ff[2:0] == 3'd0) begin
                     crc_in = ors_pkg::crc_byte(crc_ff, byte_sel);
                  end
                  if (bit_pos_ff >= ors_pkg::LAST_BIT) begin
                     result.done_res = 1'b1;
                     if (crc_in == 8'd0 && rom_in[7:0] != 8'd0) begin
                        last_disc_in = zero_pos_in;
                        last_dev_in  = (zero_pos_in == '0);
                        searching_in = 1'b0;
                        result.found = 1'b1;
                     end else begin
                        last_disc_in = '0;
                        fam_disc_in  = '0;
                        last_dev_in  = 1'b0;
                        searching_in = 1'b0;
                     end
                  end else begin
                     bit_pos_in = bit_pos_ff + 7'd1;
                  end
               end
            end
         end
         default: begin
            // Spare code: ignore.
         end
      endcase

      result.rom_code           = rom_in;
      result.family_discrepancy = fam_disc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff       <= '0;
         last_disc_ff <= '0;
         fam_disc_ff  <= '0;
         last_dev_ff  <= 1'b0;
         crc_ff       <= '0;
         bit_pos_ff   <= ors_pkg::FIRST_BIT;
         zero_pos_ff  <= '0;
         searching_ff <= 1'b0;
      end else if (fire) begin
         rom_ff       <= rom_in;
         last_disc_ff <= last_disc_in;
         fam_disc_ff  <= fam_disc_in;
         last_dev_ff  <= last_dev_in;
         crc_ff       <= crc_in;
         bit_pos_ff   <= bit_pos_in;
         zero_pos_ff  <= zero_pos_in;
         searching_ff <= searching_in;
      end
   end

endmodule

/* rtl/ors_out_reg.sv */
// Result register stage: hold one result item until the consumer takes it.
module ors_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ors_pkg::rsp_item_type result,
   output logic                  take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ors_pkg::rsp_item_type rsp_item
);

   logic                  valid_ff, valid_in;
   ors_pkg::rsp_item_type item_ff, item_in;

   // Room for a new result when empty or when the held one leaves now.
   assign take = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = load;
         item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

/* rtl/onewire_rom_search.sv */
// Top level of the 1-Wire Search ROM engine with stream request and response channels.
//
//   channel | dir | handshake            | tuser                | tdata
//   --------+-----+----------------------+----------------------+-----------------------------
//   req     | in  | req_tvalid/tready    | [1:0] func           | [0] presence, [1] id_bit,
//           |     |                      |                      | [2] complement_bit
//   rsp     | out | rsp_tvalid/tready    | [0] write_valid,     | [0] write_bit, [64:1] rom_code,
//           |     |                      | [1] done_res,[2] found| [68:65] family_discrepancy
//
// Every request item yields exactly one response item, held in the input register and then in
// the result register. While the response is not stalled, one item is accepted per cycle; the
// search state updates combinationally between the two, so throughput is one item per clock.
// Reset (synchronous, high) clears the search state: no stored code, bit position one.
// A stalled response holds the result register; the input register then fills and
// req_tready drops until the response is taken.
module onewire_rom_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [1:0]                      req_tuser,  // [1:0] func
   input  logic [ors_pkg::REQ_DATA_W-1:0]  req_tdata,  // [0] presence, [1] id_bit,
                                                       // [2] complement_bit, rest zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ors_pkg::RSP_USER_W-1:0]  rsp_tuser,  // [0] write_valid, [1] done_res,
                                                       // [2] found
   output logic [ors_pkg::RSP_DATA_W-1:0]  rsp_tdata   // [0] write_bit, [64:1] rom_code,
                                                       // [68:65] family_discrepancy, rest zero
);

   ors_pkg::req_item_type req_item;
   ors_pkg::req_item_type item;
   ors_pkg::rsp_item_type result;
   ors_pkg::rsp_item_type rsp_item;
   logic                  item_valid;
   logic                  take;
   logic                  fire;

   // Unpack the request fields.
   assign req_item.func           = req_tuser;
   assign req_item.presence       = req_tdata[0];
   assign req_item.id_bit         = req_tdata[1];
   assign req_item.complement_bit = req_tdata[2];

   ors_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // Advance the held item into the engine when the result register has room.
   assign fire = item_valid && take;

   ors_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   ors_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the response fields, lowest bit first.
   assign rsp_tuser = {rsp_item.found, rsp_item.done_res, rsp_item.write_valid};
   assign rsp_tdata = {3'b000, rsp_item.family_discrepancy, rsp_item.rom_code,
                       rsp_item.write_bit};

endmodule

/* rtl/ors_checker.sv */
// Port-level checks for the 1-Wire ROM search engine, bound to the top level.
module ors_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ors_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input logic [ors_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A stalled response item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response item changed while stalled");

   // Found is only reported on the item that ends the search.
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1] && rsp_tuser[0])
      else $error("found without done or without a final bit write");

   // A found code never has an all-zero family byte.
   a_found_family: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tdata[8:1] != 8'd0)
      else $error("found code with zero family byte");

   // No direction bit without a write.
   a_wbit_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tdata[0])
      else $error("write bit set without write valid");

   // Family discrepancy lies within the family byte.
   a_fam_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[68:65] <= 4'd8)
      else $error("family discrepancy out of range");

endmodule

bind onewire_rom_search ors_checker u_ors_checker (.*);
